### src/abm_pkg.sv
package abm_pkg;

    // default sizes of the matcher
    localparam int PATTERN_BITS_DEF = 64;
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int ERROR_LIMIT_DEF  = 8;

    // word field widths
    localparam int MODE_W     = 2;
    localparam int SYMBOL_W   = 8;
    localparam int PINDEX_W   = 6;
    localparam int POSITION_W = 32;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int PLEN_W      = 7;
    localparam int MAXERR_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ERRORS     = 1'd1;

    // word modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd3;

    // control handed to every row cell
    typedef struct packed {
        logic start;
        logic step;
    } t_cell_ctl;

    // write command to the mask table
    typedef struct packed {
        logic clear;
        logic load;
    } t_mask_cmd;

endpackage

### src/abm_in_if.sv
interface abm_in_if;
    logic                          valid;
    logic                          ready;
    logic [abm_pkg::MODE_W-1:0]    mode;
    logic [abm_pkg::SYMBOL_W-1:0]  symbol;
    logic [abm_pkg::PINDEX_W-1:0]  pattern_index;

    modport source (output valid, output mode, output symbol, output pattern_index,
                    input ready);
    modport sink   (input valid, input mode, input symbol, input pattern_index,
                    output ready);
endinterface

### src/abm_out_if.sv
interface abm_out_if;
    logic                            valid;
    logic                            ready;
    logic [abm_pkg::POSITION_W-1:0]  end_position;

    modport source (output valid, output end_position, input ready);
    modport sink   (input valid, input end_position, output ready);
endinterface

### src/abm_mask_mem.sv
module abm_mask_mem #(
    parameter int PATTERN_BITS = abm_pkg::PATTERN_BITS_DEF,
    parameter int SYMBOL_COUNT = abm_pkg::SYMBOL_COUNT_DEF,
    localparam int AW = $clog2(SYMBOL_COUNT)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    input  abm_pkg::t_mask_cmd      i_cmd,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [PATTERN_BITS-1:0] i_wr_data,
    output logic [PATTERN_BITS-1:0] o_rd_mask
);

    localparam logic [PATTERN_BITS-1:0] ONES = {PATTERN_BITS{1'b1}};

    logic [PATTERN_BITS-1:0] r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic [PATTERN_BITS-1:0] r_q;
    logic                    r_q_valid;
    logic                    r_fwd_clear;
    logic                    r_fwd_load;
    logic [PATTERN_BITS-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // entries not written since reset or the last clear read as all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
        end else if (i_cmd.load) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // catch a write committed on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q_valid   <= r_valid[i_rd_addr];
            r_fwd_clear <= i_cmd.clear;
            r_fwd_load  <= i_cmd.load && (i_wr_addr == i_rd_addr);
            r_fwd_data  <= i_wr_data;
        end
    end

    always_comb begin
        if (r_fwd_clear) begin
            o_rd_mask = ONES;
        end else if (r_fwd_load) begin
            o_rd_mask = r_fwd_data;
        end else if (r_q_valid) begin
            o_rd_mask = r_q;
        end else begin
            o_rd_mask = ONES;
        end
    end

endmodule

### src/abm_cell.sv
module abm_cell #(
    parameter int PATTERN_BITS = abm_pkg::PATTERN_BITS_DEF,
    parameter int LEVEL        = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  abm_pkg::t_cell_ctl      i_ctl,
    input  logic [PATTERN_BITS-1:0] i_mask,
    input  logic [PATTERN_BITS-1:0] i_prev_old,
    input  logic [PATTERN_BITS-1:0] i_prev_new,
    output logic [PATTERN_BITS-1:0] o_row_old,
    output logic [PATTERN_BITS-1:0] o_row_new
);

    localparam logic [PATTERN_BITS-1:0] ONES  = {PATTERN_BITS{1'b1}};
    localparam logic [PATTERN_BITS-1:0] START = ONES << LEVEL;

    logic [PATTERN_BITS-1:0] r_row;
    logic [PATTERN_BITS-1:0] n_row;
    logic [PATTERN_BITS-1:0] sh_own;
    logic [PATTERN_BITS-1:0] sh_old;
    logic [PATTERN_BITS-1:0] sh_new;
    logic [PATTERN_BITS-1:0] gate;

    always_comb begin
        sh_own = r_row << 1;
        sh_old = i_prev_old << 1;
        sh_new = i_prev_new << 1;
        // substitution, deletion and insertion paths from the row above
        gate   = (LEVEL == 0) ? ONES : (sh_old & sh_new & i_prev_old);
        n_row  = (sh_own | i_mask) & gate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= ONES;
        end else if (i_ctl.start) begin
            r_row <= START;
        end else if (i_ctl.step) begin
            r_row <= n_row;
        end
    end

    assign o_row_old = r_row;
    assign o_row_new = n_row;

endmodule

### src/approximate_bitap_matcher.sv
// A text word is held in stage 1 while its mask is read; its end position is then registered for o_out.
// Throughput: one word per cycle while no result stalls; all k+1 rows step together on each text word.
// A waiting result stalls only a text word that also matches; other words flow on.
// Reset (synchronous, active low): rows to all ones, position to zero, registers to
// defaults, mask table valid bits cleared at once so every entry reads all ones.
module approximate_bitap_matcher #(
    parameter int PATTERN_BITS = abm_pkg::PATTERN_BITS_DEF,
    parameter int SYMBOL_COUNT = abm_pkg::SYMBOL_COUNT_DEF,
    parameter int ERROR_LIMIT  = abm_pkg::ERROR_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    abm_in_if.sink                             i_in,
    abm_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [abm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [abm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ROWS = ERROR_LIMIT + 1;
    localparam int KW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW   = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
    localparam int AW   = $clog2(SYMBOL_COUNT);
    localparam logic [PATTERN_BITS-1:0] ONES = {PATTERN_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration: store the match bit and tested row already saturated
    // ------------------------------------------------------------------
    logic [BW-1:0]                  r_bidx;
    logic [KW-1:0]                  r_kidx;
    logic [BW-1:0]                  n_bidx;
    logic [KW-1:0]                  n_kidx;
    logic [abm_pkg::PLEN_W-1:0]     cfg_m;
    logic [abm_pkg::MAXERR_W:0]     cfg_k;

    always_comb begin
        cfg_m = i_cfg_data[abm_pkg::PLEN_W-1:0];
        if (cfg_m == '0) begin
            cfg_m = abm_pkg::PLEN_W'(1);
        end
        if (cfg_m > abm_pkg::PLEN_W'(PATTERN_BITS)) begin
            cfg_m = abm_pkg::PLEN_W'(PATTERN_BITS);
        end
        n_bidx = BW'(cfg_m - abm_pkg::PLEN_W'(1));

        cfg_k = {1'b0, i_cfg_data[abm_pkg::MAXERR_W-1:0]};
        if (cfg_k > (abm_pkg::MAXERR_W + 1)'(ERROR_LIMIT)) begin
            cfg_k = (abm_pkg::MAXERR_W + 1)'(ERROR_LIMIT);
        end
        n_kidx = KW'(cfg_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx <= '0;
            r_kidx <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == abm_pkg::CFG_PATTERN_LENGTH) begin
                r_bidx <= n_bidx;
            end
            if (i_cfg_index == abm_pkg::CFG_MAX_ERRORS) begin
                r_kidx <= n_kidx;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the accepted word while the mask table read returns
    // ------------------------------------------------------------------
    logic                             r_s1_valid;
    logic [abm_pkg::MODE_W-1:0]       r_s1_mode;
    logic [abm_pkg::SYMBOL_W-1:0]     r_s1_sym;
    logic [abm_pkg::PINDEX_W-1:0]     r_s1_pidx;

    logic in_accept;
    logic in_ready;
    logic s1_go;
    logic produce;
    logic hit;
    logic sym_ok;
    logic pidx_ok;
    logic is_text;

    logic [PATTERN_BITS-1:0] mem_mask;
    logic [PATTERN_BITS-1:0] mask_eff;
    logic [PATTERN_BITS-1:0] bit_clr;

    abm_pkg::t_mask_cmd mask_cmd;
    abm_pkg::t_cell_ctl cell_ctl;

    assign in_accept  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode <= i_in.mode;
            r_s1_sym  <= i_in.symbol;
            r_s1_pidx <= i_in.pattern_index;
        end
    end

    // Symbols past the alphabet match nothing; loads past the table drop.
    assign sym_ok   = {1'b0, r_s1_sym} < (abm_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT);
    assign pidx_ok  = {1'b0, r_s1_pidx} < (abm_pkg::PINDEX_W + 1)'(PATTERN_BITS);
    assign mask_eff = sym_ok ? mem_mask : ONES;
    assign bit_clr  = ~(PATTERN_BITS'(1) << r_s1_pidx);
    assign is_text  = r_s1_valid && (r_s1_mode == abm_pkg::MODE_TEXT);

    // Advance unless a match would land on a full, stalled output register.
    // Hold the input off while reset is applied.
    assign produce  = is_text && hit;
    assign s1_go    = r_s1_valid && (!produce || !o_out.valid || o_out.ready);
    assign in_ready = i_rst_n && (!r_s1_valid || s1_go);

    always_comb begin
        mask_cmd.clear = s1_go && (r_s1_mode == abm_pkg::MODE_CLEAR);
        mask_cmd.load  = s1_go && (r_s1_mode == abm_pkg::MODE_LOAD) && sym_ok && pidx_ok;
        cell_ctl.start = s1_go && (r_s1_mode == abm_pkg::MODE_START);
        cell_ctl.step  = s1_go && (r_s1_mode == abm_pkg::MODE_TEXT);
    end

    abm_mask_mem #(
        .PATTERN_BITS (PATTERN_BITS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_mask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in.symbol[AW-1:0]),
        .i_cmd     (mask_cmd),
        .i_wr_addr (r_s1_sym[AW-1:0]),
        .i_wr_data (mask_eff & bit_clr),
        .o_rd_mask (mem_mask)
    );

    // ------------------------------------------------------------------
    // Error rows: one cell per allowed error count, chained by row
    // ------------------------------------------------------------------
    logic [PATTERN_BITS-1:0] row_old [ROWS];
    logic [PATTERN_BITS-1:0] row_new [ROWS];

    for (genvar j = 0; j < ROWS; j++) begin : g_row
        logic [PATTERN_BITS-1:0] prev_old;
        logic [PATTERN_BITS-1:0] prev_new;

        if (j == 0) begin : g_head
            assign prev_old = ONES;
            assign prev_new = ONES;
        end else begin : g_link
            assign prev_old = row_old[j-1];
            assign prev_new = row_new[j-1];
        end

        abm_cell #(
            .PATTERN_BITS (PATTERN_BITS),
            .LEVEL        (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_mask     (mask_eff),
            .i_prev_old (prev_old),
            .i_prev_new (prev_new),
            .o_row_old  (row_old[j]),
            .o_row_new  (row_new[j])
        );
    end

    // match: bit m-1 of the tested row clear after this symbol
    assign hit = !row_new[r_kidx][r_bidx];

    // ------------------------------------------------------------------
    // Text position and output register
    // ------------------------------------------------------------------
    logic [abm_pkg::POSITION_W-1:0] r_pos;
    logic                           r_out_valid;
    logic [abm_pkg::POSITION_W-1:0] r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (cell_ctl.start) begin
            r_pos <= '0;
        end else if (cell_ctl.step) begin
            r_pos <= r_pos + abm_pkg::POSITION_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && produce) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && produce) begin
            r_out_pos <= r_pos;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.end_position = r_out_pos;

endmodule

### src/abm_checker.sv
module abm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [abm_pkg::MODE_W-1:0]      i_in_mode,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [abm_pkg::POSITION_W-1:0]  i_out_pos
);

    // hold a result word until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pos))
        else $error("stalled end position changed");

    // input stalls only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    // a fresh result comes from an accepted text word, held in stage 1 and then in the output register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_in_mode == abm_pkg::MODE_TEXT), 2))
        else $error("result without a text word");

endmodule

bind approximate_bitap_matcher abm_checker u_abm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pos   (o_out.end_position)
);
